// ===== rtl/core/power_meter_frame_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Power meter frame decoder - assertion macros
// Property wrappers for the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef POWER_METER_FRAME_DECODER_TOP_DEFINES_SVH
`define POWER_METER_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define PMFD_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMFD_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmfd_pkg
// Types, constants and helper functions of the power meter frame decoder.
// ----------------------------------------------------------------------------
package pmfd_pkg;

  localparam int FRAME_LEN   = 24;
  localparam int POS_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 24;
  localparam int COEF_W      = 10;
  localparam int VALUE_W     = 16;
  localparam int TEXT_W      = 32;
  localparam int DIGIT_W     = 14;
  localparam int DIV_N_W     = WORD_W + COEF_W;
  localparam int DIV_R_W     = WORD_W + 1;
  localparam int DIV_STEPS   = DIV_N_W;
  localparam int DIV_CNT_W   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int CFG_INDEX_W = 2;

  // divide by 100 as x * ceil(2^30 / 100) >> 30, exact for x below 6553600
  localparam int SCALE_IN_W   = 23;
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_PROD_W = SCALE_IN_W + WORD_W;

  localparam logic [BYTE_W-1:0]  HDR_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0]  HDR_SECOND = 8'h5A;
  localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = 16'hFFFF;
  localparam logic [VALUE_W-1:0] TEXT_LIMIT = 16'd10000;
  localparam logic [WORD_W-1:0]  RECIP_100  = 24'd10737419;
  // smallest product whose scaled reading exceeds 65535
  localparam logic [DIV_N_W-1:0] SCALE_SAT_LIMIT = 34'd6553600;

  localparam logic [COEF_W-1:0] VOLTAGE_COEF_RST = 10'd188;
  localparam logic [COEF_W-1:0] CURRENT_COEF_RST = 10'd50;

  localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_COEF = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_COEF = 2'd1;

  // frame byte positions of the four words
  localparam logic [POS_W-1:0] POS_HDR_END = 5'd2;
  localparam logic [POS_W-1:0] POS_VP_LAST = 5'd4;
  localparam logic [POS_W-1:0] POS_VR_LAST = 5'd7;
  localparam logic [POS_W-1:0] POS_CP_LAST = 5'd10;
  localparam logic [POS_W-1:0] POS_CR_LAST = 5'd13;

  typedef struct packed {
    logic [WORD_W-1:0] voltage_param;
    logic [WORD_W-1:0] voltage_period;
    logic [WORD_W-1:0] current_param;
    logic [WORD_W-1:0] current_period;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [DIGIT_W-1:0] digit_weight(input logic [1:0] idx);
    logic [DIGIT_W-1:0] w;
    case (idx)
      2'd0:    w = 14'd1000;
      2'd1:    w = 14'd100;
      2'd2:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  // how many multiples of w fit in v, v < 10*w
  function automatic logic [3:0] digit_count(input logic [DIGIT_W-1:0] v,
                                             input logic [DIGIT_W-1:0] w);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= DIGIT_W'(k) * w) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

endpackage

// ===== rtl/core/pmfd_front.sv =====
// ----------------------------------------------------------------------------
// pmfd_front
// Header sync, byte counting and word assembly; pushes one job per frame.
// ----------------------------------------------------------------------------
module pmfd_front import pmfd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   rx_byte,
  input  queue_status_t       q_status,
  output logic                q_push,
  output job_t                q_job
);

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_HALF    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  phase_t           phase;
  logic [POS_W-1:0] pos;
  job_t             job;
  job_t             job_next;
  logic             accept;
  logic             last;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    job_next = job;
    if (pos >= POS_HDR_END && pos <= POS_VP_LAST) begin
      job_next.voltage_param = {job.voltage_param[WORD_W-BYTE_W-1:0], rx_byte};
    end else if (pos > POS_VP_LAST && pos <= POS_VR_LAST) begin
      job_next.voltage_period = {job.voltage_period[WORD_W-BYTE_W-1:0], rx_byte};
    end else if (pos > POS_VR_LAST && pos <= POS_CP_LAST) begin
      job_next.current_param = {job.current_param[WORD_W-BYTE_W-1:0], rx_byte};
    end else if (pos > POS_CP_LAST && pos <= POS_CR_LAST) begin
      job_next.current_period = {job.current_period[WORD_W-BYTE_W-1:0], rx_byte};
    end
  end

  assign last   = ({1'b0, pos} + (POS_W+1)'(1)) >= (POS_W+1)'(FRAME_LEN);
  assign q_push = accept && (phase == PH_COLLECT) && last;
  assign q_job  = job_next;

  always_ff @(posedge clk) begin
    if (accept && phase == PH_COLLECT) begin
      job <= job_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      pos   <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HALF: begin
          if (rx_byte == HDR_SECOND) begin
            phase <= PH_COLLECT;
            pos   <= POS_HDR_END;
          end else if (rx_byte != HDR_FIRST) begin
            phase <= PH_SEARCH;
            pos   <= '0;
          end
        end
        PH_COLLECT: begin
          if (last) begin
            phase <= PH_SEARCH;
            pos   <= '0;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        default: begin
          phase <= (rx_byte == HDR_FIRST) ? PH_HALF : PH_SEARCH;
          pos   <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pmfd_queue.sv =====
// ----------------------------------------------------------------------------
// pmfd_queue
// Short job queue between the frame front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module pmfd_queue import pmfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  job_t          push_job,
  input  logic          pop,
  output job_t          pop_job,
  output queue_status_t status
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_job      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/pmfd_back.sv =====
// ----------------------------------------------------------------------------
// pmfd_back
// Per-frame arithmetic: restoring divider, coefficient multiply, reciprocal
// divide by 100, saturation, decimal digits, and the result register.
// ----------------------------------------------------------------------------
module pmfd_back import pmfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  queue_status_t      q_status,
  input  job_t               q_job,
  output logic               q_pop,
  input  logic [COEF_W-1:0]  voltage_coef,
  input  logic [COEF_W-1:0]  current_coef,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] voltage_value,
  output logic [VALUE_W-1:0] current_value,
  output logic [TEXT_W-1:0]  voltage_text,
  output logic [TEXT_W-1:0]  current_text,
  output logic               divide_error
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'd0,
    B_SETUP = 3'd1,
    B_DIV1  = 3'd2,
    B_MUL   = 3'd3,
    B_SCALE = 3'd4,
    B_SAT   = 3'd5,
    B_DIGIT = 3'd6,
    B_DONE  = 3'd7
  } bstate_t;

  localparam logic CH_VOLTAGE = 1'b0;
  localparam logic CH_CURRENT = 1'b1;

  bstate_t              state;
  job_t                 job;
  logic                 ch;
  logic [DIV_N_W-1:0]   num;
  logic [DIV_R_W-1:0]   rem;
  logic [WORD_W-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIGIT_W-1:0]   dr;
  logic [1:0]           didx;
  logic [TEXT_W-1:0]    txt;

  logic [WORD_W-1:0]       cur_param;
  logic [WORD_W-1:0]       cur_period;
  logic [COEF_W-1:0]       cur_coef;
  logic [DIV_R_W-1:0]      rem_sh;
  logic [DIV_R_W-1:0]      rem_diff;
  logic                    ge;
  logic [DIV_N_W-1:0]      prod;
  logic                    scale_over;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [VALUE_W-1:0]      sat_val;
  logic [DIGIT_W-1:0]      weight;
  logic [3:0]              dcnt;
  logic [DIGIT_W-1:0]      dsub;
  logic [BYTE_W-1:0]       digit;

  assign cur_param  = (ch == CH_CURRENT) ? job.current_param  : job.voltage_param;
  assign cur_period = (ch == CH_CURRENT) ? job.current_period : job.voltage_period;
  assign cur_coef   = (ch == CH_CURRENT) ? current_coef : voltage_coef;

  // one quotient bit per cycle
  assign rem_sh   = {rem[DIV_R_W-2:0], num[DIV_N_W-1]};
  assign ge       = rem_sh >= {1'b0, den};
  assign rem_diff = rem_sh - {1'b0, den};

  assign prod    = num[WORD_W-1:0] * cur_coef;
  assign sat_val = (num[DIV_N_W-1:VALUE_W] != '0) ? VALUE_MAX : num[VALUE_W-1:0];

  // below the saturation limit the product fits in SCALE_IN_W bits
  assign scale_over = num >= SCALE_SAT_LIMIT;
  assign recip_prod = RECIP_PROD_W'(num[SCALE_IN_W-1:0]) * RECIP_PROD_W'(RECIP_100);

  assign weight = digit_weight(didx);
  assign dcnt   = digit_count(dr, weight);
  assign dsub   = DIGIT_W'(dcnt) * weight;
  assign digit  = ASCII_ZERO + BYTE_W'(dcnt);

  assign q_pop = (state == B_IDLE) && !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      out_valid    <= 1'b0;
      divide_error <= 1'b0;
      voltage_text <= '0;
      current_text <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_status.empty) begin
            job          <= q_job;
            ch           <= CH_VOLTAGE;
            divide_error <= 1'b0;
            state        <= B_SETUP;
          end
        end
        B_SETUP: begin
          if (cur_period == '0) begin
            divide_error <= 1'b1;
            if (ch == CH_CURRENT) begin
              current_value <= '0;
              state         <= B_DONE;
              out_valid     <= 1'b1;
            end else begin
              voltage_value <= '0;
              ch            <= CH_CURRENT;
            end
          end else begin
            num   <= DIV_N_W'(cur_param);
            den   <= cur_period;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIV1;
          end
        end
        B_DIV1: begin
          rem <= ge ? rem_diff : rem_sh;
          num <= {num[DIV_N_W-2:0], ge};
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(DIV_STEPS-1)) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          // quotient fits in the low word; scale by coefficient
          num   <= prod;
          state <= B_SCALE;
        end
        B_SCALE: begin
          // all ones makes B_SAT clamp to the maximum
          num   <= scale_over ? '1 :
                   DIV_N_W'(recip_prod[RECIP_SHIFT+VALUE_W-1:RECIP_SHIFT]);
          state <= B_SAT;
        end
        B_SAT: begin
          if (ch == CH_CURRENT) begin
            current_value <= sat_val;
          end else begin
            voltage_value <= sat_val;
          end
          if (sat_val < TEXT_LIMIT) begin
            dr    <= sat_val[DIGIT_W-1:0];
            didx  <= '0;
            state <= B_DIGIT;
          end else if (ch == CH_CURRENT) begin
            state     <= B_DONE;
            out_valid <= 1'b1;
          end else begin
            ch    <= CH_CURRENT;
            state <= B_SETUP;
          end
        end
        B_DIGIT: begin
          txt  <= {txt[TEXT_W-BYTE_W-1:0], digit};
          dr   <= dr - dsub;
          didx <= didx + 2'd1;
          if (didx == 2'd3) begin
            if (ch == CH_CURRENT) begin
              current_text <= {txt[TEXT_W-BYTE_W-1:0], digit};
              state        <= B_DONE;
              out_valid    <= 1'b1;
            end else begin
              voltage_text <= {txt[TEXT_W-BYTE_W-1:0], digit};
              ch           <= CH_CURRENT;
              state        <= B_SETUP;
            end
          end
        end
        B_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/power_meter_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// power_meter_frame_decoder_top
// Energy meter UART frame decoder: header sync, word capture, scaled readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, rx_byte) takes one received byte per
//   transfer, one transfer per cycle while in_stall is low. The front end
//   hunts for 55 5A, collects the 24-byte frame and queues its four words.
//   The output channel (out_valid/out_stall) gives one result per frame.
//   After the last frame byte, plus any queue wait, each channel passes a
//   34-step restoring division, one multiply, a reciprocal multiply for the
//   divide by 100, saturation and four digit steps before out_valid; a reading
//   of 10000 or more skips the digit steps and a zero period skips the rest.
//   The back end works on one frame at a time and returns to idle only once
//   its result is taken; the front end keeps collecting frames meanwhile.
//   The queue holds two frames; when full, in_stall rises until the back end
//   takes one. A stalled result holds steady until out_stall drops.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   coefficients; cfg_ready is always high. Write only while idle.
//   Reset (rst, synchronous) restores coefficients 188 and 50, clears held
//   text to zero bytes and returns the header search to its start.
// ----------------------------------------------------------------------------
module power_meter_frame_decoder_top import pmfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [BYTE_W-1:0]      rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_W-1:0]     voltage_value,
  output logic [VALUE_W-1:0]     current_value,
  output logic [TEXT_W-1:0]      voltage_text,
  output logic [TEXT_W-1:0]      current_text,
  output logic                   divide_error,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]      cfg_data
);

  logic [COEF_W-1:0] voltage_coef;
  logic [COEF_W-1:0] current_coef;
  queue_status_t     q_status;
  logic              q_push;
  logic              q_pop;
  job_t              push_job;
  job_t              pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_coef <= VOLTAGE_COEF_RST;
      current_coef <= CURRENT_COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VOLTAGE_COEF: voltage_coef <= cfg_data;
        CFG_CURRENT_COEF: current_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  pmfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  pmfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  pmfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .voltage_coef  (voltage_coef),
    .current_coef  (current_coef),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .voltage_value (voltage_value),
    .current_value (current_value),
    .voltage_text  (voltage_text),
    .current_text  (current_text),
    .divide_error  (divide_error)
  );

endmodule

// ===== rtl/core/pmfd_checker.sv =====
// ----------------------------------------------------------------------------
// pmfd_checker
// Port-level checks on the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "power_meter_frame_decoder_top_defines.svh"

module pmfd_checker import pmfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] voltage_value,
  input logic [VALUE_W-1:0] current_value,
  input logic [TEXT_W-1:0]  voltage_text,
  input logic [TEXT_W-1:0]  current_text,
  input logic               divide_error
);

  // a stalled result keeps its values
  `PMFD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(voltage_value) && $stable(current_value) && $stable(divide_error), "stalled result changed")

  // divide error forces at least one reading to zero
  `PMFD_ASSERT_IMP(a_err_zero, clk, rst, out_valid && divide_error, voltage_value == '0 || current_value == '0, "divide error without zero reading")

  // a fresh small reading leaves ASCII digits in every byte
  `PMFD_ASSERT_IMP(a_text_digits, clk, rst, out_valid && !divide_error && voltage_value < TEXT_LIMIT && current_value < TEXT_LIMIT, voltage_text[31:28] == 4'h3 && voltage_text[23:20] == 4'h3 && voltage_text[15:12] == 4'h3 && voltage_text[7:4] == 4'h3 && current_text[31:28] == 4'h3 && current_text[23:20] == 4'h3 && current_text[15:12] == 4'h3 && current_text[7:4] == 4'h3, "held text not ASCII digits")

  // coming out of reset nothing is pending
  `PMFD_ASSERT_IMP(a_reset_clear, clk, rst, $past(rst), !out_valid && !in_stall, "state not clear after reset")

endmodule

bind power_meter_frame_decoder_top pmfd_checker u_pmfd_checker (.*);
